// File: hw/rtl/i8bsdp_pkg.sv
// ============================================================================
// i8bsdp_pkg: shared types and float helpers
// Payload structs, the command format between front and back, and
// IEEE single-precision multiply and add with round to nearest even.
// ============================================================================
package i8bsdp_pkg;

    localparam int          BLOCK_SIZE    = 32;
    localparam int          POS_W         = $clog2(BLOCK_SIZE);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_SIZE - 1);
    localparam logic [31:0] CANON_NAN     = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO      = 32'h0000_0000;
    localparam logic        MODE_DOT      = 1'b0;
    localparam logic        MODE_DEQUANT  = 1'b1;

    typedef struct packed {
        logic signed [7:0] weight;
        logic [31:0]       activation;
        logic [31:0]       block_scale;
        logic [31:0]       prior_output;
        logic              last_in_row;
    } t_in;

    typedef struct packed {
        logic [31:0] result_value;
        logic        is_row_sum;
    } t_out;

    // One queued job for the back end: the item and how to handle it.
    typedef struct packed {
        t_in  item;
        logic dequant;
    } t_cmd;

    // Normalize, round to nearest even and pack. The value is
    // m / 2^47 * 2^(e - 127).
    function automatic logic [31:0] fp_pack(input logic s, input int e,
                                            input logic [47:0] m);
        logic [47:0] mm;
        int          ee;
        int          sh;
        int          lz;
        logic        found;
        logic        stk;
        logic [23:0] man;
        logic        rnd;
        logic [31:0] base;
        if (m == 48'd0) begin
            return {s, 31'd0};
        end
        lz    = 0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && m[i]) begin
                lz    = 47 - i;
                found = 1'b1;
            end
        end
        mm = m << lz;
        ee = e - lz;
        if (ee < 1) begin
            sh = 1 - ee;
            if (sh > 48) begin
                sh = 48;
            end
            stk   = |(mm & ((48'd1 << sh) - 48'd1));
            mm    = mm >> sh;
            mm[0] = mm[0] | stk;
            ee    = 0;
        end
        if (ee >= 255) begin
            return {s, 8'hFF, 23'd0};
        end
        man  = mm[47:24];
        rnd  = mm[23] & ((|mm[22:0]) | man[0]);
        base = (ee >= 1) ? (32'(ee - 1) << 23) : 32'd0;
        base = base + {8'd0, man} + {31'd0, rnd};
        if (base >= 32'h7F80_0000) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, base[30:0]};
    endfunction

    function automatic logic [31:0] fp_from_int8(input logic signed [7:0] w);
        logic [7:0] mag;
        mag = w[7] ? 8'(-w) : 8'(w);
        return fp_pack(w[7], 134, {mag, 40'd0});
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0] ma, mb;
        int          ea, eb;
        logic [47:0] p;
        s      = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            return CANON_NAN;
        end
        if (a_inf || b_inf) begin
            return {s, 8'hFF, 23'd0};
        end
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        p  = ma * mb;
        return fp_pack(s, ea + eb - 126, p);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic        a_nan, b_nan, a_inf, b_inf;
        int          ex, ey, d;
        logic [47:0] xa, xb, sum;
        logic        stk;
        logic        s;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            return CANON_NAN;
        end
        if (a_inf) begin
            return a;
        end
        if (b_inf) begin
            return b;
        end
        // Larger magnitude goes first so the difference stays non-negative.
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
        d  = ex - ey;
        if (d > 48) begin
            d = 48;
        end
        xa    = {1'b0, (x[30:23] != 8'd0), x[22:0], 23'd0};
        xb    = {1'b0, (y[30:23] != 8'd0), y[22:0], 23'd0};
        stk   = |(xb & ((48'd1 << d) - 48'd1));
        xb    = xb >> d;
        xb[0] = xb[0] | stk;
        sum   = (x[31] != y[31]) ? (xa - xb) : (xa + xb);
        s     = (sum == 48'd0) ? (x[31] & y[31]) : x[31];
        return fp_pack(s, ex + 1, sum);
    endfunction

endpackage

// File: hw/rtl/i8bsdp_front.sv
// ============================================================================
// i8bsdp_front: intake and classification
// Accepts items, tags each with its handling from the mode register, and
// holds them in a two-entry queue for the back end.
// ============================================================================
module i8bsdp_front
    import i8bsdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_mode,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_cmd_valid,
    input  logic i_cmd_pop,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr].item    <= i_in_data;
            r_slot[r_wr_ptr].dequant <= (i_mode == MODE_DEQUANT);
        end
    end

endmodule

// File: hw/rtl/i8bsdp_back.sv
// ============================================================================
// i8bsdp_back: arithmetic sequencer
// Runs one queued item at a time through a float multiply and, in dot mode,
// float adds, one operation per cycle unless it waits on the result side,
// and owns the accumulators and the result register.
module i8bsdp_back
    import i8bsdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    input  t_cmd i_cmd,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_ADD1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_ADD2 = 3'd4;
    localparam logic [2:0] S_ADD3 = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]       r_state;
    t_cmd             r_cmd;
    logic [31:0]      r_tmp;
    logic [31:0]      r_bsum;
    logic [31:0]      r_rsum;
    logic [POS_W-1:0] r_pos;
    logic             r_ovalid;
    t_out             r_out;
    logic             out_free;

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bsum   <= POS_ZERO;
            r_rsum   <= POS_ZERO;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (r_cmd.dequant) begin
                        r_tmp   <= fp_mul(r_cmd.item.block_scale,
                                          fp_from_int8(r_cmd.item.weight));
                        r_state <= S_EMIT;
                    end else begin
                        r_tmp   <= fp_mul(fp_from_int8(r_cmd.item.weight),
                                          r_cmd.item.activation);
                        r_state <= S_ADD1;
                    end
                end
                S_ADD1: begin
                    r_bsum <= fp_add(r_bsum, r_tmp);
                    if (r_pos == LAST_POS || r_cmd.item.last_in_row) begin
                        r_state <= S_MUL2;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MUL2: begin
                    // Close the block with the scale carried by this item.
                    r_tmp   <= fp_mul(r_cmd.item.block_scale, r_bsum);
                    r_bsum  <= POS_ZERO;
                    r_pos   <= '0;
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    r_rsum  <= fp_add(r_rsum, r_tmp);
                    r_state <= r_cmd.item.last_in_row ? S_ADD3 : S_IDLE;
                end
                S_ADD3: begin
                    r_tmp   <= fp_add(r_cmd.item.prior_output, r_rsum);
                    r_rsum  <= POS_ZERO;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out.result_value <= r_tmp;
            r_out.is_row_sum   <= !r_cmd.dequant;
        end
    end

endmodule

// File: hw/rtl/int8_block_scaled_dot_product.sv
// ============================================================================
// int8_block_scaled_dot_product: block-scaled int8 dot product
// Dot mode accumulates weight times activation per 32-weight block, scales
// each closed block into a row sum and emits prior output plus row sum at the
// end of a row. Dequantize mode emits scale times weight for every item.
// ============================================================================
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  -------------------------
//  input    in         i_in_valid / o_in_ready   i_in_data (t_in)
//  result   out        o_out_valid / i_out_ready o_out_data (t_out)
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_mode (1 bit)
//
// A dot-mode item inside a block passes through the back end as dequeue,
// multiply and add; a block close adds a scale multiply and a row-sum add,
// and a row end adds the prior-output add plus the transfer into the result
// register. A dequantize item is dequeued, multiplied and transferred. The
// back-end sequencer runs the steps one at a time; each sum waits on the last.
// Reset is synchronous and active low; it clears the sums, block position
// and mode. The two-entry queue lets intake continue while the back end or
// the result side stalls.
module int8_block_scaled_dot_product
    import i8bsdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_mode
);

    logic r_mode;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Always ready; the user must send writes only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DOT;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_mode;
        end
    end

    i8bsdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    i8bsdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sim/tb_int8_block_scaled_dot_product.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_int8_block_scaled_dot_product: self-checking testbench
// Drives weight items through the block in dot and dequantize mode, predicts
// every result with an independent IEEE single-precision model and compares
// each output transfer against the oldest predicted result.
// ============================================================================
module tb_int8_block_scaled_dot_product;
    import i8bsdp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int DRAIN_WAIT  = 24;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_mode;

    int8_block_scaled_dot_product dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_mode  (i_cfg_mode)
    );

    // Predictor state, a private copy of what the block holds.
    logic              mode_q;
    logic [POS_W-1:0]  pos_q;
    logic [31:0]       block_acc;
    logic [31:0]       row_acc;

    t_out pending_results[$];
    int   error_count;
    int   cycle_count;
    int   burst_left;
    int   stall_style;

    // ------------------------------------------------------------------
    // Independent single-precision arithmetic. A value is carried as an
    // integer magnitude times a power of two and rounded once at the end.
    // ------------------------------------------------------------------
    function automatic logic [31:0] sp_round(input logic s, input logic [63:0] mag,
                                             input int exp2);
        int           msb;
        int           top;
        int           sh;
        logic [127:0] ext;
        logic [127:0] rem;
        logic [127:0] half;
        logic [63:0]  q;
        longint       bits;
        if (mag == 64'd0) begin
            return {s, 31'd0};
        end
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) begin
                msb = i;
            end
        end
        top = msb + exp2;
        sh  = (top < -126) ? (-149 - exp2) : (top - 23 - exp2);
        if (sh > 0) begin
            if (sh > 100) begin
                sh = 100;
            end
            ext  = {64'd0, mag};
            q    = 64'(ext >> sh);
            rem  = ext & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end else begin
            q = mag << (-sh);
        end
        // A subnormal that rounds up to 2^23 lands on the smallest normal.
        if (top < -126) begin
            bits = longint'(q);
        end else begin
            bits = (longint'(top + 126) <<< 23) + longint'(q);
        end
        if (bits >= 64'h7F80_0000) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, bits[30:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) begin
            return CANON_NAN;
        end
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) begin
            return CANON_NAN;
        end
        if (is_inf(a) || is_inf(b)) begin
            return {s, 8'hFF, 23'd0};
        end
        ma = {40'd0, a[30:23] != 8'd0, a[22:0]};
        mb = {40'd0, b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        return sp_round(s, ma * mb, ea + eb - 300);
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [63:0] xm;
        logic [63:0] ym;
        logic [63:0] sum;
        logic        sticky;
        int          ex;
        int          ey;
        int          d;
        if (is_nan(a) || is_nan(b)) begin
            return CANON_NAN;
        end
        if (is_inf(a) && is_inf(b)) begin
            return (a[31] == b[31]) ? a : CANON_NAN;
        end
        if (is_inf(a)) begin
            return a;
        end
        if (is_inf(b)) begin
            return b;
        end
        if (a[30:0] >= b[30:0]) begin
            big = a;
            lit = b;
        end else begin
            big = b;
            lit = a;
        end
        ex = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
        ey = (lit[30:23] == 8'd0) ? 1 : int'(lit[30:23]);
        d  = ex - ey;
        if (d > 60) begin
            d = 60;
        end
        // 26 guard bits below the mantissa leave room for the sticky bit.
        xm     = {40'd0, big[30:23] != 8'd0, big[22:0]} << 26;
        ym     = {40'd0, lit[30:23] != 8'd0, lit[22:0]} << 26;
        sticky = |(ym & ((64'd1 << d) - 64'd1));
        ym     = (ym >> d) | {63'd0, sticky};
        sum    = (big[31] == lit[31]) ? (xm + ym) : (xm - ym);
        if (sum == 64'd0) begin
            return {big[31] & lit[31], 31'd0};
        end
        return sp_round(big[31], sum, ex - 176);
    endfunction

    function automatic logic [31:0] sp_from_weight(input logic signed [7:0] w);
        logic [63:0] mag;
        mag = w[7] ? 64'(-int'(w)) : 64'(int'(w));
        return sp_round(w[7], mag, 0);
    endfunction

    // Work out what one accepted item produces and queue it.
    task automatic predict_item(input t_in it);
        logic [31:0] wf;
        t_out        r;
        wf = sp_from_weight(it.weight);
        if (mode_q == MODE_DEQUANT) begin
            r.result_value = sp_mul(it.block_scale, wf);
            r.is_row_sum   = 1'b0;
            pending_results.push_back(r);
        end else begin
            block_acc = sp_add(block_acc, sp_mul(wf, it.activation));
            // A row that stops mid-block closes that block with its own scale.
            if (pos_q == LAST_POS || it.last_in_row) begin
                row_acc   = sp_add(row_acc, sp_mul(it.block_scale, block_acc));
                block_acc = POS_ZERO;
                pos_q     = '0;
            end else begin
                pos_q = pos_q + 1'b1;
            end
            if (it.last_in_row) begin
                r.result_value = sp_add(it.prior_output, row_acc);
                r.is_row_sum   = 1'b1;
                row_acc        = POS_ZERO;
                pending_results.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit and the result checker.
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Each output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_value %h is_row_sum %b",
                       o_out_data.result_value, o_out_data.is_row_sum);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_value !== want.result_value) begin
                    $error("result_value: expected %h, actual %h",
                           want.result_value, o_out_data.result_value);
                    error_count++;
                end
                if (o_out_data.is_row_sum !== want.is_row_sum) begin
                    $error("is_row_sum: expected %b, actual %b",
                           want.is_row_sum, o_out_data.is_row_sum);
                    error_count++;
                end
            end
        end
    end

    // The receiver has stall patterns of its own, switched now and then.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            stall_style = $urandom_range(0, 3);
        end
        case (stall_style)
            0: begin
                i_out_ready = 1'b1;
            end
            1: begin
                i_out_ready = ($urandom_range(0, 1) == 1);
            end
            2: begin
                i_out_ready = ($urandom_range(0, 7) == 0);
            end
            default: begin
                i_out_ready = ((cycle_count % 11) < 6);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared stimulus helpers.
    // ------------------------------------------------------------------
    // The sender works in bursts; between bursts it leaves a random gap.
    task automatic send_item(input t_in it);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_data  = it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_item(it);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Wait for every predicted result, then let the back end settle.
    task automatic wait_idle();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_mode  = m;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        mode_q = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        case ($urandom_range(0, 15))
            0: v = POS_ZERO;
            1: v = 32'h8000_0000;
            2: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            3: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            4: v = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
            5: v = {$urandom_range(0, 1) == 1, 8'($urandom_range(240, 254)), 23'($urandom())};
            6: v = $urandom();
            default: begin
                v = {$urandom_range(0, 1) == 1, 8'($urandom_range(112, 140)),
                     23'($urandom())};
            end
        endcase
        return v;
    endfunction

    function automatic t_in make_item(input logic last);
        t_in it;
        case ($urandom_range(0, 9))
            0: it.weight = 8'sh7F;
            1: it.weight = 8'sh80;
            2: it.weight = 8'sh00;
            default: it.weight = 8'($urandom());
        endcase
        it.activation   = rand_float();
        it.block_scale  = rand_float();
        it.prior_output = rand_float();
        it.last_in_row  = last;
        return it;
    endfunction

    function automatic t_in fixed_item(input logic signed [7:0] w, input logic [31:0] act,
                                       input logic [31:0] sc, input logic [31:0] pr,
                                       input logic last);
        t_in it;
        it.weight       = w;
        it.activation   = act;
        it.block_scale  = sc;
        it.prior_output = pr;
        it.last_in_row  = last;
        return it;
    endfunction

    // A well-formed row of random content and the given length.
    task automatic send_row(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(make_item(i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Extreme weights, special floats, a row ending mid-block, a full block
    // and a row that runs one past a block boundary.
    task automatic test_dot_directed();
        write_mode(MODE_DOT);
        send_item(fixed_item(8'sh7F, 32'h3F80_0000, 32'h4000_0000, POS_ZERO, 1'b0));
        send_item(fixed_item(8'sh80, 32'hBF80_0000, 32'h3F00_0000, 32'h3F80_0000, 1'b1));
        send_item(fixed_item(8'sh00, 32'h7F80_0000, 32'h3F80_0000, POS_ZERO, 1'b1));
        send_item(fixed_item(8'sh01, 32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000, 1'b1));
        send_item(fixed_item(8'sh05, 32'h7FC0_1234, 32'h3F80_0000, POS_ZERO, 1'b1));
        send_item(fixed_item(8'sh03, 32'h0000_0001, 32'h0080_0000, 32'h8000_0000, 1'b1));
        send_item(fixed_item(8'sh7F, 32'h7F7F_FFFF, 32'h7F7F_FFFF, POS_ZERO, 1'b1));
        // Scales on items before the closing one must be ignored.
        send_item(fixed_item(8'sh02, 32'h3F80_0000, 32'h7F80_0000, POS_ZERO, 1'b0));
        send_item(fixed_item(8'sh03, 32'h3F80_0000, 32'h4040_0000, POS_ZERO, 1'b1));
        send_row(32);
        send_row(33);
        send_row(1);
        wait_idle();
    endtask

    task automatic test_dequant_directed();
        write_mode(MODE_DEQUANT);
        send_item(fixed_item(8'sh7F, POS_ZERO, 32'h3F80_0000, POS_ZERO, 1'b0));
        send_item(fixed_item(8'sh80, POS_ZERO, 32'h8000_0001, POS_ZERO, 1'b1));
        send_item(fixed_item(8'sh00, POS_ZERO, 32'h7F80_0000, POS_ZERO, 1'b0));
        send_item(fixed_item(8'sh40, POS_ZERO, 32'h7F7F_FFFF, POS_ZERO, 1'b0));
        send_item(fixed_item(8'sh11, POS_ZERO, 32'hFFFF_FFFF, POS_ZERO, 1'b1));
        wait_idle();
    endtask

    // Leaving dot mode mid-row keeps the partial sums for later.
    task automatic test_mode_switch_mid_row();
        write_mode(MODE_DOT);
        for (int i = 0; i < 7; i++) begin
            send_item(make_item(1'b0));
        end
        write_mode(MODE_DEQUANT);
        send_row(4);
        write_mode(MODE_DOT);
        send_row(30);
        wait_idle();
    endtask

    // Phases of random length and mode; a dot phase may stop mid-row.
    task automatic test_random_traffic();
        int sent;
        int phase_end;
        int len;
        sent = 0;
        while (sent < 2000) begin
            write_mode($urandom_range(0, 2) == 0 ? MODE_DEQUANT : MODE_DOT);
            phase_end = sent + $urandom_range(60, 250);
            while (sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(33, 96);
                    1: begin
                        // A stray item with a random row end.
                        send_item(make_item($urandom_range(0, 1) == 1));
                        len = 0;
                        sent++;
                    end
                    default: len = $urandom_range(1, 32);
                endcase
                if (len > 0) begin
                    send_row(len);
                    sent += len;
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_mode  = MODE_DOT;
        mode_q      = MODE_DOT;
        pos_q       = '0;
        block_acc   = POS_ZERO;
        row_acc     = POS_ZERO;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        stall_style = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_dot_directed();
        test_dequant_directed();
        test_mode_switch_mid_row();
        test_random_traffic();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/i8bsdp_pkg.sv
hw/rtl/i8bsdp_front.sv
hw/rtl/i8bsdp_back.sv
hw/rtl/int8_block_scaled_dot_product.sv
sim/tb_int8_block_scaled_dot_product.sv
